// ===== hdl/connect_frame_deframer_defines.svh =====
// Assertion macros shared by the connect frame deframer checkers.
`ifndef CONNECT_FRAME_DEFRAMER_DEFINES_SVH
`define CONNECT_FRAME_DEFRAMER_DEFINES_SVH

// Check cons in the cycle after ante holds.
`define CFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed: next-cycle rule");

// Check cons in the same cycle as ante.
`define CFD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed: same-cycle rule");

`endif

// ===== hdl/cfd_pkg.sv =====
// Types and constants shared by the connect frame deframer modules.
`timescale 1ns / 1ps

package cfd_pkg;

   // Configuration register indexes
   localparam logic [1:0] REG_REQUEST_MODE  = 2'd0;
   localparam logic [1:0] REG_VERSION_CODE  = 2'd1;
   localparam logic [1:0] REG_REQUEST_TYPE  = 2'd2;
   localparam logic [1:0] REG_RESPONSE_TYPE = 2'd3;

   // Result kinds
   localparam logic [1:0] KIND_HOST = 2'd0;
   localparam logic [1:0] KIND_DONE = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_BAD_VERSION  = 2'd1;
   localparam logic [1:0] ST_BAD_TYPE     = 2'd2;
   localparam logic [1:0] ST_BAD_HOSTLEN  = 2'd3;

   // Frame lengths: request header plus trailer, and a whole response
   localparam logic [8:0] REQ_OVERHEAD = 9'd5;
   localparam logic [8:0] RESP_LENGTH  = 9'd4;

   // Width of the packed result data bus
   localparam int unsigned RSP_DATA_W = 48;

   typedef struct packed {
      logic       request_mode;
      logic [7:0] version_code;
      logic [7:0] request_type_code;
      logic [7:0] response_type_code;
   } cfg_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [1:0] status;
      logic [7:0] host_byte;
      logic [7:0] host_length;
      logic [15:0] frame_value;
      logic [8:0] bytes_consumed;
   } result_type;

endpackage

// ===== hdl/cfd_csr.sv =====
// Configuration registers of the connect frame deframer.
`timescale 1ns / 1ps

module cfd_csr
   import cfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wen,
   input  logic [1:0] csr_addr,
   input  logic [7:0] csr_wdata,
   output cfg_type    cfg,
   output logic       mode_write
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write onto one register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            REG_REQUEST_MODE:  cfg_in.request_mode       = csr_wdata[0];
            REG_VERSION_CODE:  cfg_in.version_code       = csr_wdata;
            REG_REQUEST_TYPE:  cfg_in.request_type_code  = csr_wdata;
            REG_RESPONSE_TYPE: cfg_in.response_type_code = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   // Hold the registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.request_mode       <= 1'b1;
         cfg_ff.version_code       <= 8'd1;
         cfg_ff.request_type_code  <= 8'd1;
         cfg_ff.response_type_code <= 8'd2;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg        = cfg_ff;
   // A mode write drops the frame in progress
   assign mode_write = csr_wen && (csr_addr == REG_REQUEST_MODE);

endmodule

// ===== hdl/cfd_parser.sv =====
// Frame phase tracking and per-byte decode of the connect frame deframer.
`timescale 1ns / 1ps

module cfd_parser
   import cfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       restart,
   input  logic       step,
   input  logic [7:0] data_byte,
   output logic       has_result,
   output result_type result
);

   typedef enum logic [2:0] {
      PH_VERSION = 3'd0,
      PH_TYPE    = 3'd1,
      PH_HOSTLEN = 3'd2,
      PH_HOST    = 3'd3,
      PH_VAL_HI  = 3'd4,
      PH_VAL_LO  = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] remaining_ff, remaining_in;
   logic [7:0] saved_len_ff, saved_len_in;
   logic [7:0] value_hi_ff, value_hi_in;
   logic [7:0] type_expected;

   assign type_expected = cfg.request_mode ? cfg.request_type_code
                                           : cfg.response_type_code;

   // Decode one byte against the current phase
   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      saved_len_in = saved_len_ff;
      value_hi_in  = value_hi_ff;
      has_result   = 1'b0;
      result       = '0;
      unique case (phase_ff)
         PH_VERSION: begin
            if (data_byte != cfg.version_code) begin
               has_result    = 1'b1;
               result.result_kind = KIND_ERR;
               result.status = ST_BAD_VERSION;
            end else begin
               phase_in = PH_TYPE;
            end
         end
         PH_TYPE: begin
            if (data_byte != type_expected) begin
               has_result    = 1'b1;
               result.result_kind = KIND_ERR;
               result.status = ST_BAD_TYPE;
               phase_in      = PH_VERSION;
            end else begin
               phase_in = cfg.request_mode ? PH_HOSTLEN : PH_VAL_HI;
            end
         end
         PH_HOSTLEN: begin
            if (data_byte == 8'd0) begin
               has_result    = 1'b1;
               result.result_kind = KIND_ERR;
               result.status = ST_BAD_HOSTLEN;
               phase_in      = PH_VERSION;
            end else begin
               saved_len_in = data_byte;
               remaining_in = data_byte;
               phase_in     = PH_HOST;
            end
         end
         PH_HOST: begin
            remaining_in     = remaining_ff - 8'd1;
            has_result       = 1'b1;
            result.result_kind = KIND_HOST;
            result.host_byte = data_byte;
            if (remaining_ff == 8'd1) begin
               phase_in = PH_VAL_HI;
            end
         end
         PH_VAL_HI: begin
            value_hi_in = data_byte;
            phase_in    = PH_VAL_LO;
         end
         PH_VAL_LO: begin
            has_result         = 1'b1;
            result.result_kind = KIND_DONE;
            result.frame_value = {value_hi_ff, data_byte};
            if (cfg.request_mode) begin
               result.host_length    = saved_len_ff;
               result.bytes_consumed = {1'b0, saved_len_ff} + REQ_OVERHEAD;
            end else begin
               result.bytes_consumed = RESP_LENGTH;
            end
            phase_in     = PH_VERSION;
            remaining_in = 8'd0;
            saved_len_in = 8'd0;
            value_hi_in  = 8'd0;
         end
         default: begin
            phase_in = PH_VERSION;
         end
      endcase
      // An error restarts the frame
      if (has_result && (result.result_kind == KIND_ERR)) begin
         phase_in     = PH_VERSION;
         remaining_in = 8'd0;
         saved_len_in = 8'd0;
         value_hi_in  = 8'd0;
      end
   end

   // Advance the phase on each decoded byte
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff     <= PH_VERSION;
         remaining_ff <= 8'd0;
         saved_len_ff <= 8'd0;
         value_hi_ff  <= 8'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         saved_len_ff <= saved_len_in;
         value_hi_ff  <= value_hi_in;
      end
   end

endmodule

// ===== hdl/connect_frame_deframer.sv =====
// Top level of the connect frame deframer: input and result registers.
`timescale 1ns / 1ps

// Takes one frame byte per item and sustains one item per clock cycle. Each
// byte is captured in an input register, decoded combinationally against
// the frame phase and, when it yields a result (a host byte, a finished
// frame or an error), written into the result register. Bytes that finish
// nothing are consumed without a result. A result waiting on rsp_tready
// stalls decode, so the input side keeps flowing only while the result
// register is free or being drained. A write to the request mode register
// drops any frame in progress.
module connect_frame_deframer
   import cfd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Byte stream in
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   // Results out
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [1:0] status, [9:2] host_byte, [17:10] host_length, [33:18] frame_value,
   // [42:34] bytes_consumed, [47:43] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // [1:0] result_kind
   // Configuration writes
   input  logic                  csr_wen,
   input  logic [1:0]            csr_addr,
   input  logic [7:0]            csr_wdata
);

   cfg_type    cfg;
   logic       mode_write;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   result_type out_ff;
   logic       decode_fire;
   logic       has_result;
   result_type result;

   cfd_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cfg        (cfg),
      .mode_write (mode_write)
   );

   cfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (mode_write),
      .step       (decode_fire),
      .data_byte  (in_byte_ff),
      .has_result (has_result),
      .result     (result)
   );

   // Decode when a byte waits and the result register can take its result
   assign decode_fire = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || decode_fire;

   // Hold the input byte
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= decode_fire && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (decode_fire && has_result) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.result_kind;
   assign rsp_tdata  = {5'd0, out_ff.bytes_consumed, out_ff.frame_value,
                        out_ff.host_length, out_ff.host_byte, out_ff.status};

endmodule

// ===== hdl/cfd_checker.sv =====
// Port-level checks for the connect frame deframer, bound to the top level.
`timescale 1ns / 1ps
`include "connect_frame_deframer_defines.svh"

module cfd_checker
   import cfd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser
);

   logic stalled;
   logic show_host;
   logic show_err;
   logic kind_legal;
   logic host_clean;
   logic err_clean;

   assign stalled    = rsp_tvalid && !rsp_tready;
   assign show_host  = rsp_tvalid && (rsp_tuser == KIND_HOST);
   assign show_err   = rsp_tvalid && (rsp_tuser == KIND_ERR);
   assign kind_legal = (rsp_tuser == KIND_HOST) || (rsp_tuser == KIND_DONE) ||
                       (rsp_tuser == KIND_ERR);
   assign host_clean = (rsp_tdata[1:0] == ST_OK) && (rsp_tdata[47:10] == 38'd0);
   assign err_clean  = (rsp_tdata[1:0] != ST_OK) && (rsp_tdata[47:2] == 46'd0);

   // A stalled result stays and keeps its contents
   `CFD_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid)
   `CFD_ASSERT_NEXT(a_rsp_stable, clock, reset, stalled, $stable({rsp_tuser, rsp_tdata}))

   // No result carries the unused kind code
   `CFD_ASSERT_NOW(a_kind_legal, clock, reset, rsp_tvalid, kind_legal)

   // A host byte carries nothing but the byte
   `CFD_ASSERT_NOW(a_host_clean, clock, reset, show_host, host_clean)

   // An error carries a failing status and no payload
   `CFD_ASSERT_NOW(a_err_clean, clock, reset, show_err, err_clean)

endmodule

bind connect_frame_deframer cfd_checker u_cfd_checker (.*);
